// ===== rtl/core/tar_pkg.sv =====
// tar_pkg: shared types and constants for the axis reduction block.
// No dependencies; imported by the modules under rtl/core other than tar_ram.
package tar_pkg;

  localparam int ACC_W      = 48;   // accumulator / partial width
  localparam int OIDX_W     = 24;   // output index width
  localparam int SPAN_W     = 11;   // inner_span register width
  localparam int LEN_W      = 17;   // axis_length register width
  localparam int AXIS_W     = 16;   // axis position counter width
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam int MAX_INNER_DEF  = 1024;
  localparam int DATA_WIDTH_DEF = 32;

  localparam logic MODE_SUM = 1'b0;
  localparam logic MODE_MIN = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPAN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEN  = 2'd2;

  // per-element control travelling with the element into the update stage
  typedef struct packed {
    logic first;   // first contribution along the axis: load directly
    logic last;    // last contribution along the axis
    logic mode;
  } elem_ctl_t;

  // update stage status seen by the top level
  typedef struct packed {
    logic s1_valid;
    logic s1_adv;
    logic fwd_hit;
  } upd_stat_t;

endpackage

// ===== rtl/core/tar_ram.sv =====
// tar_ram: single-port-write / single-port-read accumulator memory,
// registered read data, read returns old data on a same-address write.
module tar_ram #(
  parameter int DEPTH  = 1024,
  parameter int WIDTH  = 48,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/tar_pos_ctr.sv =====
// tar_pos_ctr: position counters (inner, axis, outer block) and address
// generation for each accepted element. Depends on tar_pkg.
module tar_pos_ctr #(
  parameter int MAX_INNER = tar_pkg::MAX_INNER_DEF,
  parameter int POS_W     = 10
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_fire,
  input  logic                        start_of_array,
  input  logic                        mode,
  input  logic [tar_pkg::SPAN_W-1:0]  inner_span,
  input  logic [tar_pkg::LEN_W-1:0]   axis_length,
  output logic [POS_W-1:0]            slot,
  output logic [tar_pkg::OIDX_W-1:0]  idx_base,
  output tar_pkg::elem_ctl_t          ctl
);
  import tar_pkg::*;

  localparam int CAP = (MAX_INNER > 2047) ? 2047 : MAX_INNER;
  localparam logic [SPAN_W-1:0] CAP_V = SPAN_W'(CAP);
  localparam int CMP_W = LEN_W + 1;
  localparam int PROD_W = OIDX_W + SPAN_W;

  logic [POS_W-1:0]  inner_r, inner_nxt, inner_cur;
  logic [AXIS_W-1:0] axis_r, axis_nxt, axis_cur;
  logic [OIDX_W-1:0] outer_r, outer_nxt, outer_cur;
  logic [SPAN_W-1:0] span_nz, span_eff;
  logic [LEN_W-1:0]  len_eff;
  logic              last_in_row, last_on_axis;

  always_comb begin
    span_nz  = (inner_span == '0) ? SPAN_W'(1) : inner_span;
    span_eff = (span_nz > CAP_V) ? CAP_V : span_nz;
    len_eff  = (axis_length == '0) ? LEN_W'(1) : axis_length;

    // start of array clears the counters before this element
    inner_cur = start_of_array ? '0 : inner_r;
    axis_cur  = start_of_array ? '0 : axis_r;
    outer_cur = start_of_array ? '0 : outer_r;

    // a position at or past its bound counts as the last one
    last_in_row  = (CMP_W'(inner_cur) + CMP_W'(1)) >= CMP_W'(span_eff);
    last_on_axis = (CMP_W'(axis_cur) + CMP_W'(1)) >= CMP_W'(len_eff);

    inner_nxt = inner_cur;
    axis_nxt  = axis_cur;
    outer_nxt = outer_cur;
    if (!last_in_row) begin
      inner_nxt = inner_cur + POS_W'(1);
    end else begin
      inner_nxt = '0;
      if (!last_on_axis) begin
        axis_nxt = axis_cur + AXIS_W'(1);
      end else begin
        axis_nxt  = '0;
        outer_nxt = outer_cur + OIDX_W'(1);
      end
    end

    slot      = inner_cur;
    idx_base  = OIDX_W'(PROD_W'(outer_cur) * PROD_W'(span_eff));
    ctl.first = (axis_cur == '0);
    ctl.last  = last_on_axis;
    ctl.mode  = mode;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inner_r <= '0;
      axis_r  <= '0;
      outer_r <= '0;
    end else if (in_fire) begin
      inner_r <= inner_nxt;
      axis_r  <= axis_nxt;
      outer_r <= outer_nxt;
    end
  end

endmodule

// ===== rtl/core/tar_update.sv =====
// tar_update: read-modify-write stage with forwarding, plus the output
// register. Depends on tar_pkg; reads tar_ram data in the cycle after issue.
module tar_update #(
  parameter int DATA_WIDTH = tar_pkg::DATA_WIDTH_DEF,
  parameter int POS_W      = 10
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_fire,
  input  logic [POS_W-1:0]                  slot,
  input  logic [tar_pkg::OIDX_W-1:0]        idx_base,
  input  tar_pkg::elem_ctl_t                ctl,
  input  logic signed [DATA_WIDTH-1:0]      value,
  input  logic [tar_pkg::ACC_W-1:0]         rd_data,
  output logic                              in_ready,
  output logic                              wr_en,
  output logic [POS_W-1:0]                  wr_addr,
  output logic [tar_pkg::ACC_W-1:0]         wr_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [tar_pkg::OIDX_W-1:0]        out_index,
  output logic signed [tar_pkg::ACC_W-1:0]  out_partial,
  output logic                              out_entry_final,
  output tar_pkg::upd_stat_t                stat
);
  import tar_pkg::*;

  logic                     s1_valid_r;
  logic [POS_W-1:0]         s1_slot_r;
  logic [OIDX_W-1:0]        s1_base_r;
  elem_ctl_t                s1_ctl_r;
  logic signed [ACC_W-1:0]  s1_value_r;
  logic                     fwd_hit_r;
  logic signed [ACC_W-1:0]  fwd_data_r;

  logic                     out_valid_r;
  logic [OIDX_W-1:0]        out_index_r;
  logic signed [ACC_W-1:0]  out_partial_r;
  logic                     out_final_r;

  logic                     s1_adv;
  logic signed [ACC_W-1:0]  old_acc, acc;

  always_comb begin
    s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
    in_ready = !s1_valid_r || s1_adv;

    old_acc = fwd_hit_r ? fwd_data_r : $signed(rd_data);
    if (s1_ctl_r.first) begin
      acc = s1_value_r;
    end else if (s1_ctl_r.mode == MODE_MIN) begin
      acc = (s1_value_r < old_acc) ? s1_value_r : old_acc;
    end else begin
      acc = old_acc + s1_value_r;
    end
  end

  assign wr_en   = s1_adv;
  assign wr_addr = s1_slot_r;
  assign wr_data = acc;

  // output index is the block base plus the slot index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      fwd_hit_r   <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
        // memory read at this edge misses the write done at the same edge
        fwd_hit_r  <= s1_adv && (s1_slot_r == slot);
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_slot_r  <= slot;
      s1_base_r  <= idx_base;
      s1_ctl_r   <= ctl;
      s1_value_r <= ACC_W'(value);
      fwd_data_r <= acc;
    end
    if (s1_adv) begin
      out_index_r   <= s1_base_r + OIDX_W'(s1_slot_r);
      out_partial_r <= acc;
      out_final_r   <= s1_ctl_r.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_index       = out_index_r;
  assign out_partial     = out_partial_r;
  assign out_entry_final = out_final_r;

  assign stat.s1_valid = s1_valid_r;
  assign stat.s1_adv   = s1_adv;
  assign stat.fwd_hit  = fwd_hit_r;

endmodule

// ===== rtl/core/tensor_axis_reduce.sv =====
// tensor_axis_reduce: streaming sum / minimum reduction along one axis.
// Steps: memory read (into the update stage), then update (into the output register).
// Throughput: one element per cycle unless out_ready stalls it; a new element may
//   read the entry the previous one writes, served by a one-entry forwarding register.
// Reset (rst_n, synchronous): counters and handshake state clear, registers
//   return to sum mode, span 1, length 1; accumulator memory is not cleared.
module tensor_axis_reduce #(
  parameter int MAX_INNER  = tar_pkg::MAX_INNER_DEF,
  parameter int DATA_WIDTH = tar_pkg::DATA_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tar_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tar_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_start_of_array,
  input  logic signed [DATA_WIDTH-1:0]         in_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [tar_pkg::OIDX_W-1:0]           out_index,
  output logic signed [tar_pkg::ACC_W-1:0]     out_partial,
  output logic                                 out_entry_final
);
  import tar_pkg::*;

  localparam int POS_W = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;

  logic              mode_r;
  logic [SPAN_W-1:0] span_r;
  logic [LEN_W-1:0]  len_r;

  logic              in_fire;
  logic [POS_W-1:0]  slot;
  logic [OIDX_W-1:0] idx_base;
  elem_ctl_t         ctl;
  logic              wr_en;
  logic [POS_W-1:0]  wr_addr;
  logic [ACC_W-1:0]  wr_data, rd_data;
  upd_stat_t         stat;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_SUM;
      span_r <= SPAN_W'(1);
      len_r  <= LEN_W'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MODE: mode_r <= cfg_data[0];
        CFG_SPAN: span_r <= cfg_data[SPAN_W-1:0];
        CFG_LEN:  len_r  <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  tar_pos_ctr #(
    .MAX_INNER (MAX_INNER),
    .POS_W     (POS_W)
  ) u_pos (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_fire        (in_fire),
    .start_of_array (in_start_of_array),
    .mode           (mode_r),
    .inner_span     (span_r),
    .axis_length    (len_r),
    .slot           (slot),
    .idx_base       (idx_base),
    .ctl            (ctl)
  );

  tar_ram #(
    .DEPTH  (MAX_INNER),
    .WIDTH  (ACC_W),
    .ADDR_W (POS_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (in_fire),
    .rd_addr (slot),
    .rd_data (rd_data)
  );

  tar_update #(
    .DATA_WIDTH (DATA_WIDTH),
    .POS_W      (POS_W)
  ) u_upd (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_fire         (in_fire),
    .slot            (slot),
    .idx_base        (idx_base),
    .ctl             (ctl),
    .value           (in_value),
    .rd_data         (rd_data),
    .in_ready        (in_ready),
    .wr_en           (wr_en),
    .wr_addr         (wr_addr),
    .wr_data         (wr_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_index       (out_index),
    .out_partial     (out_partial),
    .out_entry_final (out_entry_final),
    .stat            (stat)
  );

  // a write to the accumulators always hands a result to the output register
  a_wr_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> out_valid)
    else $error("accumulator write without result");

  // same-entry read during write must be served from the forwarding register
  a_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && wr_en && (wr_addr == slot) |=> stat.fwd_hit)
    else $error("missed forwarding on same-entry access");

  // a new transfer never lands on an update stage that is not moving
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && stat.s1_valid |-> stat.s1_adv)
    else $error("update stage overrun");

  // an accepted element is in the update stage on the next cycle
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> stat.s1_valid)
    else $error("accepted element lost");

endmodule

// ===== tb/tb_tensor_axis_reduce.sv =====
// tb_tensor_axis_reduce: self-checking bench for the sum/min axis reduction block.
// A directed table is followed by random phases. Typed rows are compared with their
// stored result, others with an in-bench model; depends on tar_pkg, tensor_axis_reduce.
`timescale 1ns / 100ps

module tb_tensor_axis_reduce;
  import tar_pkg::*;

  localparam int SLOTS          = MAX_INNER_DEF;
  localparam int DW             = DATA_WIDTH_DEF;
  localparam int RANDOM_ITEMS   = 1400;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int MAX_REPORTS    = 200;

  typedef struct packed {
    logic [OIDX_W-1:0]       idx;
    logic signed [ACC_W-1:0] part;
    logic                    fin;
  } reduce_out_t;

  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
    logic                  start;
    logic [DW-1:0]         value;
    logic                  typed;
    reduce_out_t           want;
  } plan_row_t;

  localparam reduce_out_t NO_RESULT = '0;
  localparam int PLAN_ROWS = 39;

  // Directed sequence; typed rows carry their result, the rest use the model.
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    // reset settings: sum, span 1, length 1 -> every element is final
    '{1'b0, CFG_MODE, 17'd0, 1'b1, 32'h7FFFFFFF, 1'b1, '{24'd0, 48'sd2147483647, 1'b1}},
    '{1'b0, CFG_MODE, 17'd0, 1'b0, 32'h80000000, 1'b1, '{24'd1, -48'sd2147483648, 1'b1}},
    '{1'b0, CFG_MODE, 17'd0, 1'b0, 32'h00000000, 1'b1, '{24'd2, 48'sd0, 1'b1}},
    '{1'b0, CFG_MODE, 17'd0, 1'b0, 32'hFFFFFFFF, 1'b1, '{24'd3, -48'sd1, 1'b1}},
    // sums of extremes over length 2
    '{1'b1, CFG_LEN,  17'd2, 1'b0, 32'h0, 1'b0, NO_RESULT},
    '{1'b0, CFG_MODE, 17'd0, 1'b1, 32'h7FFFFFFF, 1'b1, '{24'd0, 48'sd2147483647, 1'b0}},
    '{1'b0, CFG_MODE, 17'd0, 1'b0, 32'h7FFFFFFF, 1'b1, '{24'd0, 48'sd4294967294, 1'b1}},
    '{1'b0, CFG_MODE, 17'd0, 1'b0, 32'h80000000, 1'b1, '{24'd1, -48'sd2147483648, 1'b0}},
    '{1'b0, CFG_MODE, 17'd0, 1'b0, 32'h80000000, 1'b1, '{24'd1, -48'sd4294967296, 1'b1}},
    // minimum
    '{1'b1, CFG_MODE, 17'(MODE_MIN), 1'b0, 32'h0, 1'b0, NO_RESULT},
    '{1'b0, CFG_MODE, 17'd0, 1'b1, 32'h00000005, 1'b1, '{24'd0, 48'sd5, 1'b0}},
    '{1'b0, CFG_MODE, 17'd0, 1'b0, 32'hFFFFFFF9, 1'b1, '{24'd0, -48'sd7, 1'b1}},
    '{1'b0, CFG_MODE, 17'd0, 1'b0, 32'h00000003, 1'b1, '{24'd1, 48'sd3, 1'b0}},
    '{1'b0, CFG_MODE, 17'd0, 1'b0, 32'h7FFFFFFF, 1'b1, '{24'd1, 48'sd3, 1'b1}},
    // zero span and zero length behave as 1
    '{1'b1, CFG_SPAN, 17'd0, 1'b0, 32'h0, 1'b0, NO_RESULT},
    '{1'b1, CFG_LEN,  17'd0, 1'b0, 32'h0, 1'b0, NO_RESULT},
    '{1'b0, CFG_MODE, 17'd0, 1'b1, 32'hFFFFFFFB, 1'b1, '{24'd0, -48'sd5, 1'b1}},
    '{1'b0, CFG_MODE, 17'd0, 1'b0, 32'h00000009, 1'b1, '{24'd1, 48'sd9, 1'b1}},
    // oversized span saturates
    '{1'b1, CFG_SPAN, 17'd2047, 1'b0, 32'h0, 1'b0, NO_RESULT},
    '{1'b1, CFG_LEN,  17'd2, 1'b0, 32'h0, 1'b0, NO_RESULT},
    '{1'b0, CFG_MODE, 17'd0, 1'b1, 32'h00000064, 1'b1, '{24'd0, 48'sd100, 1'b0}},
    '{1'b0, CFG_MODE, 17'd0, 1'b0, 32'h80000000, 1'b1, '{24'd1, -48'sd2147483648, 1'b0}},
    // axis counter left beyond a shortened length
    '{1'b1, CFG_MODE, 17'(MODE_SUM), 1'b0, 32'h0, 1'b0, NO_RESULT},
    '{1'b1, CFG_SPAN, 17'd2, 1'b0, 32'h0, 1'b0, NO_RESULT},
    '{1'b1, CFG_LEN,  17'd3, 1'b0, 32'h0, 1'b0, NO_RESULT},
    '{1'b0, CFG_MODE, 17'd0, 1'b1, 32'd10, 1'b0, NO_RESULT},
    '{1'b0, CFG_MODE, 17'd0, 1'b0, 32'd20, 1'b0, NO_RESULT},
    '{1'b0, CFG_MODE, 17'd0, 1'b0, 32'd30, 1'b0, NO_RESULT},
    '{1'b0, CFG_MODE, 17'd0, 1'b0, 32'd40, 1'b0, NO_RESULT},
    '{1'b1, CFG_LEN,  17'd1, 1'b0, 32'h0, 1'b0, NO_RESULT},
    '{1'b0, CFG_MODE, 17'd0, 1'b0, 32'hFFFFFFFF, 1'b0, NO_RESULT},
    '{1'b0, CFG_MODE, 17'd0, 1'b0, 32'd1, 1'b0, NO_RESULT},
    // inner counter left beyond a shortened span
    '{1'b1, CFG_SPAN, 17'd3, 1'b0, 32'h0, 1'b0, NO_RESULT},
    '{1'b1, CFG_LEN,  17'd2, 1'b0, 32'h0, 1'b0, NO_RESULT},
    '{1'b0, CFG_MODE, 17'd0, 1'b1, 32'd7, 1'b0, NO_RESULT},
    '{1'b0, CFG_MODE, 17'd0, 1'b0, 32'd8, 1'b0, NO_RESULT},
    '{1'b1, CFG_SPAN, 17'd1, 1'b0, 32'h0, 1'b0, NO_RESULT},
    '{1'b0, CFG_MODE, 17'd0, 1'b0, 32'd9, 1'b0, NO_RESULT},
    '{1'b0, CFG_MODE, 17'd0, 1'b0, 32'hFFFFFFFC, 1'b0, NO_RESULT}
  };

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_DATA_W-1:0]    cfg_data;
  logic                     in_valid;
  logic                     in_ready;
  logic                     in_start_of_array;
  logic signed [DW-1:0]     in_value;
  logic                     out_valid;
  logic                     out_ready;
  logic [OIDX_W-1:0]        out_index;
  logic signed [ACC_W-1:0]  out_partial;
  logic                     out_entry_final;

  tensor_axis_reduce DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_start_of_array (in_start_of_array),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_index         (out_index),
    .out_partial       (out_partial),
    .out_entry_final   (out_entry_final)
  );

  // model state
  logic                    mode_r;
  logic [SPAN_W-1:0]       span_r;
  logic [LEN_W-1:0]        len_r;
  logic signed [ACC_W-1:0] acc_mem [SLOTS];
  bit                      written [SLOTS];
  int unsigned             inner_pos;
  int unsigned             axis_pos;
  logic [OIDX_W-1:0]       outer_blk;

  reduce_out_t due_results [$];
  int          err_cnt;
  int          idle_pct;
  bit          want_hold;

  function automatic int unsigned span_eff();
    if (span_r == 0) return 1;
    if (span_r > SLOTS) return SLOTS;
    return span_r;
  endfunction

  function automatic int unsigned len_eff();
    return (len_r == 0) ? 1 : len_r;
  endfunction

  // one element into the running reduction; returns the entry's new value
  function automatic reduce_out_t fold_element(input logic start,
                                               input logic signed [DW-1:0] v);
    int unsigned             span_e;
    int unsigned             len_e;
    int unsigned             slot;
    logic signed [ACC_W-1:0] vx;
    logic signed [ACC_W-1:0] acc;
    logic                    last_axis;
    reduce_out_t             r;
    span_e = span_eff();
    len_e  = len_eff();
    vx     = ACC_W'(v);
    if (start) begin
      inner_pos = 0;
      axis_pos  = 0;
      outer_blk = '0;
    end
    slot = inner_pos % SLOTS;
    if (axis_pos == 0) acc = vx;
    else if (mode_r == MODE_SUM) acc = acc_mem[slot] + vx;
    else acc = (vx < acc_mem[slot]) ? vx : acc_mem[slot];
    acc_mem[slot] = acc;
    written[slot] = 1'b1;
    last_axis = (axis_pos + 1 >= len_e);
    r.idx  = OIDX_W'(longint'(outer_blk) * span_e + inner_pos);
    r.part = acc;
    r.fin  = last_axis;
    if (inner_pos + 1 < span_e) begin
      inner_pos++;
    end else begin
      inner_pos = 0;
      if (!last_axis) begin
        axis_pos++;
      end else begin
        axis_pos = 0;
        outer_blk++;
      end
    end
    return r;
  endfunction

  task automatic send_elem(input logic start, input logic [DW-1:0] v,
                           input bit typed, input reduce_out_t want);
    int          gap;
    reduce_out_t got;
    gap = 0;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) gap = $urandom_range(1, 18);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_start_of_array <= start;
    in_value          <= v;
    do @(posedge clk); while (!in_ready);
    got = fold_element(start, v);
    due_results.push_back(typed ? want : got);
  endtask

  // stop offering elements and let every result drain
  task automatic settle();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
  endtask

  // cfg_valid is left high; the caller lowers it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_MODE: mode_r = data[0];
      CFG_SPAN: span_r = data[SPAN_W-1:0];
      CFG_LEN:  len_r  = data[LEN_W-1:0];
      default: ;
    endcase
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result side: checking, random stalls and the long hold-off
  initial begin
    reduce_out_t due;
    int          stall_left;
    int          hold_left;
    out_ready  = 1'b0;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display("%0t: unexpected result: expected none, got index %0d partial %0d final %0b",
                     $time, out_index, out_partial, out_entry_final);
        end else begin
          due = due_results.pop_front();
          if (out_index !== due.idx) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS)
              $display("%0t: out_index expected %0d, got %0d", $time, due.idx, out_index);
          end
          if (out_partial !== due.part) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS)
              $display("%0t: out_partial expected %0d, got %0d", $time, due.part, out_partial);
          end
          if (out_entry_final !== due.fin) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS)
              $display("%0t: out_entry_final expected %0b, got %0b",
                       $time, due.fin, out_entry_final);
          end
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (want_hold) begin
        want_hold = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        stall_left = $urandom_range(0, 17);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog: cycles without any transfer
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, quiet);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    plan_row_t         row;
    logic              start;
    logic [DW-1:0]     v;
    logic [CFG_DATA_W-1:0] span_d;
    logic [CFG_DATA_W-1:0] len_d;
    int                n_sent;
    int                phase;
    int                n_items;
    int                arr_len;
    int                arr_cnt;
    int                mask;
    bit                first;

    rst_n             = 1'b0;
    cfg_valid         = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    in_valid          = 1'b0;
    in_start_of_array = 1'b0;
    in_value          = '0;
    err_cnt           = 0;
    idle_pct          = 15;
    want_hold         = 1'b0;
    mode_r            = MODE_SUM;
    span_r            = 1;
    len_r             = 1;
    inner_pos         = 0;
    axis_pos          = 0;
    outer_blk         = '0;
    for (int k = 0; k < SLOTS; k++) begin
      acc_mem[k] = '0;
      written[k] = 1'b0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < PLAN_ROWS; i++) begin
      row = PLAN[i];
      if (row.is_cfg) begin
        if (!cfg_valid) settle();
        write_reg(row.reg_idx, row.reg_data);
      end else begin
        if (cfg_valid) cfg_valid <= 1'b0;
        send_elem(row.start, row.value, row.typed, row.want);
      end
    end

    n_sent = 0;
    phase  = 0;
    while (n_sent < RANDOM_ITEMS) begin
      phase++;
      if (n_sent >= RANDOM_ITEMS - 200 || phase == 4) idle_pct = 0;
      else if ($urandom_range(0, 3) == 0) idle_pct = 0;
      else idle_pct = $urandom_range(5, 35);
      settle();

      mask = $urandom_range(1, 7);
      if (mask[0]) write_reg(CFG_MODE, CFG_DATA_W'($urandom_range(0, 1)));
      if (mask[1]) begin
        case ($urandom_range(0, 9))
          0:       span_d = '0;
          1:       span_d = CFG_DATA_W'(SLOTS);
          2:       span_d = CFG_DATA_W'($urandom_range(SLOTS + 1, 2047));
          3:       span_d = CFG_DATA_W'($urandom_range(9, SLOTS));
          default: span_d = CFG_DATA_W'($urandom_range(1, 8));
        endcase
        write_reg(CFG_SPAN, span_d);
      end
      if (mask[2]) begin
        case ($urandom_range(0, 9))
          0:       len_d = '0;
          1:       len_d = CFG_DATA_W'(65536);
          2:       len_d = CFG_DATA_W'($urandom_range(7, 65536));
          3:       len_d = CFG_DATA_W'(1);
          default: len_d = CFG_DATA_W'($urandom_range(2, 6));
        endcase
        write_reg(CFG_LEN, len_d);
      end
      cfg_valid <= 1'b0;

      // fill the block while the result side is held off
      if (phase == 4) want_hold = 1'b1;

      n_items = $urandom_range(20, 90);
      arr_len = span_eff() * len_eff() * $urandom_range(1, 3);
      arr_cnt = 0;
      first   = ($urandom_range(0, 5) != 0);
      for (int i = 0; i < n_items; i++) begin
        if (i == 0) start = first;
        else start = (arr_cnt == arr_len) || ($urandom_range(0, 39) == 0);
        // never let an element read an accumulator that was never written
        if (axis_pos != 0 && !written[inner_pos % SLOTS]) start = 1'b1;
        if (start) arr_cnt = 0;
        case ($urandom_range(0, 7))
          0:       v = 32'h7FFFFFFF;
          1:       v = 32'h80000000;
          2:       v = $urandom_range(0, 15) - 8;
          3:       v = '0;
          default: v = $urandom();
        endcase
        send_elem(start, v, 1'b0, NO_RESULT);
        arr_cnt++;
        n_sent++;
      end
    end

    idle_pct = 0;
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
